// File: rtl/cigar_operation_tally_assert.svh
// Assertion macros for the CIGAR operation tally.
// Each macro takes a label, an antecedent and a consequent, sampled on i_clk.
`ifndef CIGAR_OPERATION_TALLY_ASSERT_SVH
`define CIGAR_OPERATION_TALLY_ASSERT_SVH
`ifndef SYNTHESIS
`define COT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");
`define COT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");
`else
`define COT_ASSERT_SAME(label, ante, cons)
`define COT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/cot_pkg.sv
`default_nettype none
package cot_pkg;

    typedef logic [3:0] t_slot;

    // Tally slots, in the order of the output ports.
    localparam t_slot SLOT_INS  = 4'd0;
    localparam t_slot SLOT_DEL  = 4'd1;
    localparam t_slot SLOT_ALN  = 4'd2;
    localparam t_slot SLOT_SKP  = 4'd3;
    localparam t_slot SLOT_SOFT = 4'd4;
    localparam t_slot SLOT_HARD = 4'd5;
    localparam t_slot SLOT_PAD  = 4'd6;
    localparam t_slot SLOT_EQ   = 4'd7;
    localparam t_slot SLOT_MIS  = 4'd8;
    localparam t_slot SLOT_NONE = 4'd15;

    localparam int NUM_SLOTS = 9;

    localparam logic [7:0] CHAR_0  = 8'h30;
    localparam logic [7:0] CHAR_9  = 8'h39;
    localparam logic [7:0] CHAR_I  = 8'h49;
    localparam logic [7:0] CHAR_D  = 8'h44;
    localparam logic [7:0] CHAR_M  = 8'h4D;
    localparam logic [7:0] CHAR_N  = 8'h4E;
    localparam logic [7:0] CHAR_S  = 8'h53;
    localparam logic [7:0] CHAR_H  = 8'h48;
    localparam logic [7:0] CHAR_P  = 8'h50;
    localparam logic [7:0] CHAR_EQ = 8'h3D;
    localparam logic [7:0] CHAR_X  = 8'h58;

    function automatic t_slot slot_of(input logic [7:0] c);
        t_slot s;
        case (c)
            CHAR_I:  s = SLOT_INS;
            CHAR_D:  s = SLOT_DEL;
            CHAR_M:  s = SLOT_ALN;
            CHAR_N:  s = SLOT_SKP;
            CHAR_S:  s = SLOT_SOFT;
            CHAR_H:  s = SLOT_HARD;
            CHAR_P:  s = SLOT_PAD;
            CHAR_EQ: s = SLOT_EQ;
            CHAR_X:  s = SLOT_MIS;
            default: s = SLOT_NONE;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// File: rtl/cigar_operation_tally.sv
// CIGAR operation tally.
// Input channel: i_valid / o_stall carry one word per character (i_character)
// with i_is_last marking the final character of a CIGAR string. Digits build a
// run length; the letters I D M N P = X add it to their totals, S and H
// overwrite their clip values. Any other character ends the number.
// Output channel: o_valid / i_stall carry one word of nine totals, produced
// once per string, on the cycle after its final character is accepted.
// Throughput is one character per cycle unless o_stall is raised: the digit
// step and the nine saturating adders sit between the state registers and the
// result register.
// o_stall is raised only while a result word waits and the receiver stalls;
// the result word holds steady until taken.
// Reset (synchronous, active low) clears the run length, the totals and the
// output valid. After the final character run length and totals return to zero.
`default_nettype none
module cigar_operation_tally #(
    parameter int COUNT_BITS = 31
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [7:0]            i_character,
    input  wire logic                  i_is_last,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [COUNT_BITS-1:0]      o_insertions,
    output logic [COUNT_BITS-1:0]      o_deletions,
    output logic [COUNT_BITS-1:0]      o_aligned_matches,
    output logic [COUNT_BITS-1:0]      o_skipped,
    output logic [COUNT_BITS-1:0]      o_soft_trim,
    output logic [COUNT_BITS-1:0]      o_hard_trim,
    output logic [COUNT_BITS-1:0]      o_padding,
    output logic [COUNT_BITS-1:0]      o_sequence_matches,
    output logic [COUNT_BITS-1:0]      o_mismatches
);
    import cot_pkg::*;

    localparam int PROD_BITS = COUNT_BITS + 4;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef logic [COUNT_BITS-1:0] t_count;

    t_count              r_run;
    logic                r_ended;
    t_count              r_tally [NUM_SLOTS];
    logic                r_out_valid;
    t_count              r_out [NUM_SLOTS];

    t_count              n_run;
    logic                n_ended;
    t_count              n_tally [NUM_SLOTS];

    logic                w_in_acc;
    logic                w_is_digit;
    t_slot               w_slot;
    logic [PROD_BITS-1:0] w_prod;
    logic [COUNT_BITS:0]  w_sum [NUM_SLOTS];

    assign o_stall  = r_out_valid && i_stall;
    assign w_in_acc = i_valid && !o_stall;

    assign w_is_digit = (i_character >= CHAR_0) && (i_character <= CHAR_9);
    assign w_slot     = slot_of(i_character);

    // run * 10 + digit; the low nibble of an ASCII digit is its value.
    assign w_prod = {3'b000, r_run, 1'b0} + {1'b0, r_run, 3'b000}
                  + PROD_BITS'(i_character[3:0]);

    always_comb begin
        n_run   = r_run;
        n_ended = r_ended;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            w_sum[k]   = {1'b0, r_tally[k]} + {1'b0, r_run};
            n_tally[k] = r_tally[k];
        end
        if (w_is_digit) begin
            if (!r_ended) begin
                if (w_prod[PROD_BITS-1:COUNT_BITS] != 4'd0) begin
                    n_run = COUNT_MAX;
                end else begin
                    n_run = w_prod[COUNT_BITS-1:0];
                end
            end
        end else if (w_slot != SLOT_NONE) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                if (w_slot == t_slot'(k)) begin
                    if (w_slot == SLOT_SOFT || w_slot == SLOT_HARD) begin
                        n_tally[k] = r_run;
                    end else if (w_sum[k][COUNT_BITS]) begin
                        n_tally[k] = COUNT_MAX;
                    end else begin
                        n_tally[k] = w_sum[k][COUNT_BITS-1:0];
                    end
                end
            end
            n_run   = '0;
            n_ended = 1'b0;
        end else begin
            n_ended = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= '0;
            r_ended     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_tally[k] <= '0;
            end
        end else begin
            if (w_in_acc) begin
                if (i_is_last) begin
                    r_run   <= '0;
                    r_ended <= 1'b0;
                    for (int k = 0; k < NUM_SLOTS; k++) begin
                        r_tally[k] <= '0;
                    end
                end else begin
                    r_run   <= n_run;
                    r_ended <= n_ended;
                    for (int k = 0; k < NUM_SLOTS; k++) begin
                        r_tally[k] <= n_tally[k];
                    end
                end
            end
            if (w_in_acc && i_is_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The result word is loaded only when the previous one has been taken.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_is_last) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_out[k] <= n_tally[k];
            end
        end
    end

    assign o_valid            = r_out_valid;
    assign o_insertions       = r_out[SLOT_INS];
    assign o_deletions        = r_out[SLOT_DEL];
    assign o_aligned_matches  = r_out[SLOT_ALN];
    assign o_skipped          = r_out[SLOT_SKP];
    assign o_soft_trim        = r_out[SLOT_SOFT];
    assign o_hard_trim        = r_out[SLOT_HARD];
    assign o_padding          = r_out[SLOT_PAD];
    assign o_sequence_matches = r_out[SLOT_EQ];
    assign o_mismatches       = r_out[SLOT_MIS];

`include "cigar_operation_tally_assert.svh"

    `COT_ASSERT_NEXT(a_last_gives_word, w_in_acc && i_is_last, o_valid)
    `COT_ASSERT_NEXT(a_last_clears_state, w_in_acc && i_is_last, r_run == '0 && !r_ended)
    `COT_ASSERT_SAME(a_stall_only_when_full, o_stall, o_valid)
    `COT_ASSERT_NEXT(a_no_spurious_word,
        !(w_in_acc && i_is_last) && !(o_valid && i_stall), !o_valid)

endmodule
`default_nettype wire
